### hdl/hkm_pkg.sv
// hkm_pkg: shared types and constants for the hotkey combo matcher
// used by hkm_ctrl, hkm_datapath and hotkey_combo_matcher; no dependencies
package hkm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_ENTRY,
      ST_CODE,
      ST_RESP
   } hkm_state_type;

   typedef enum logic [1:0] {
      OP_KEY_EVENT    = 2'd0,
      OP_WRITE_CODE   = 2'd1,
      OP_WRITE_LENGTH = 2'd2,
      OP_NONE         = 2'd3
   } hkm_op_type;

   localparam logic [1:0]  EV_RELEASE     = 2'd0;
   localparam logic [1:0]  EV_PRESS       = 2'd1;
   localparam logic [15:0] KEY_EVENT_TYPE = 16'd1;
   localparam logic [3:0]  MIN_KEYS_RESET = 4'd2;

   typedef struct packed {
      logic capture;
      logic update;
      logic entry_step;
      logic code_start;
      logic code_next;
      logic hit;
   } hkm_cmd_type;

   typedef struct packed {
      logic ready;
      logic entry_done;
      logic candidate;
      logic code_eq;
      logic last_code;
   } hkm_status_type;

endpackage

### hdl/hkm_ctrl.sv
// hkm_ctrl: state machine sequencing update, table scan and response
// depends on hkm_pkg
module hkm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  hkm_pkg::hkm_status_type status,
   output hkm_pkg::hkm_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   hkm_pkg::hkm_state_type state_ff;
   hkm_pkg::hkm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hkm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = hkm_pkg::ST_UPDATE;
            end
         end
         hkm_pkg::ST_UPDATE: begin
            state_in = hkm_pkg::ST_ENTRY;
         end
         hkm_pkg::ST_ENTRY: begin
            priority if (!status.ready || status.entry_done) begin
               state_in = hkm_pkg::ST_RESP;
            end else if (status.candidate) begin
               state_in = hkm_pkg::ST_CODE;
            end else begin
               state_in = hkm_pkg::ST_ENTRY;
            end
         end
         hkm_pkg::ST_CODE: begin
            priority if (!status.code_eq) begin
               state_in = hkm_pkg::ST_ENTRY;
            end else if (status.last_code) begin
               state_in = hkm_pkg::ST_RESP;
            end else begin
               state_in = hkm_pkg::ST_CODE;
            end
         end
         hkm_pkg::ST_RESP: begin
            state_in = hkm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hkm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         hkm_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         hkm_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         hkm_pkg::ST_ENTRY: begin
            if (status.ready && !status.entry_done) begin
               cmd.code_start = status.candidate;
               cmd.entry_step = !status.candidate;
            end
         end
         hkm_pkg::ST_CODE: begin
            priority if (!status.code_eq) begin
               cmd.entry_step = 1'b1;
            end else if (status.last_code) begin
               cmd.hit = 1'b1;
            end else begin
               cmd.code_next = 1'b1;
            end
         end
         hkm_pkg::ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

### hdl/hkm_datapath.sv
// hkm_datapath: held key list, combo flags, shortcut table and scan counters
// depends on hkm_pkg; driven by commands from hkm_ctrl
module hkm_datapath #(
   parameter int COMBO_KEYS    = 8,
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hkm_pkg::hkm_cmd_type    cmd,
   output hkm_pkg::hkm_status_type status,
   input  logic                    csr_wr_en,
   input  logic [3:0]              csr_wr_data,
   input  logic [1:0]              req_operation,
   input  logic [15:0]             req_event_type,
   input  logic [1:0]              req_event_value,
   input  logic [7:0]              req_key_code,
   input  logic [3:0]              req_entry_index,
   input  logic [2:0]              req_slot_index,
   input  logic [7:0]              req_table_code,
   input  logic [3:0]              req_entry_length,
   output logic                    rsp_combo_ready,
   output logic [3:0]              rsp_combo_size,
   output logic                    rsp_match_found,
   output logic [3:0]              rsp_match_index
);

   localparam int SLOT_W  = $clog2(COMBO_KEYS);
   localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ECNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int CNT_W   = $clog2(COMBO_KEYS + 1);
   localparam int CMP_W   = (CNT_W > 4) ? CNT_W + 1 : 5;
   localparam int MEM_D   = TABLE_ENTRIES * (2 ** SLOT_W);

   // captured transaction fields
   logic [1:0]  op_ff;
   logic [15:0] type_ff;
   logic [1:0]  value_ff;
   logic [7:0]  key_ff;
   logic [3:0]  entry_ff;
   logic [2:0]  slot_ff;
   logic [7:0]  tcode_ff;
   logic [3:0]  length_ff;

   logic [3:0]       min_keys_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] size_ff;
   logic [CNT_W-1:0] size_in;
   logic             open_ff;
   logic             open_in;
   logic             ready_ff;
   logic             ready_in;
   logic             found_ff;
   logic [ECNT_W-1:0] e_ff;
   logic [SLOT_W-1:0] k_ff;
   logic [SLOT_W-1:0] k_in;

   logic [7:0] held_ff [COMBO_KEYS];
   logic [3:0] lengths_ff [TABLE_ENTRIES];
   logic [7:0] mem [MEM_D];
   logic [7:0] rd_data_ff;

   logic                      held_wr;
   logic                      code_wr;
   logic                      len_wr;
   logic [ENTRY_W-1:0]        e_idx;
   logic [3:0]                cur_len;
   logic [SLOT_W+ENTRY_W-1:0] rd_addr;
   logic [SLOT_W+ENTRY_W-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         type_ff   <= req_event_type;
         value_ff  <= req_event_value;
         key_ff    <= req_key_code;
         entry_ff  <= req_entry_index;
         slot_ff   <= req_slot_index;
         tcode_ff  <= req_table_code;
         length_ff <= req_entry_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_keys_ff <= hkm_pkg::MIN_KEYS_RESET;
      end else if (csr_wr_en) begin
         min_keys_ff <= csr_wr_data;
      end
   end

   // key event update
   always_comb begin
      count_in = count_ff;
      size_in  = size_ff;
      open_in  = open_ff;
      ready_in = ready_ff;
      held_wr  = 1'b0;
      if (hkm_pkg::hkm_op_type'(op_ff) == hkm_pkg::OP_KEY_EVENT) begin
         priority if (type_ff != hkm_pkg::KEY_EVENT_TYPE) begin
            ready_in = 1'b0;
         end else if (value_ff == hkm_pkg::EV_RELEASE) begin
            size_in  = count_ff;
            ready_in = (CMP_W'(count_ff) >= CMP_W'(min_keys_ff)) && open_ff;
            open_in  = 1'b0;
            count_in = '0;
         end else if (value_ff == hkm_pkg::EV_PRESS) begin
            if (count_ff < CNT_W'(COMBO_KEYS)) begin
               held_wr  = 1'b1;
               count_in = count_ff + 1'b1;
            end
            size_in  = held_wr ? count_ff + 1'b1 : count_ff;
            ready_in = 1'b0;
            open_in  = 1'b1;
         end else begin
            ready_in = ready_ff;
         end
      end
   end

   assign code_wr = cmd.update
      && (hkm_pkg::hkm_op_type'(op_ff) == hkm_pkg::OP_WRITE_CODE)
      && (32'(entry_ff) < TABLE_ENTRIES) && (32'(slot_ff) < COMBO_KEYS);
   assign len_wr = cmd.update
      && (hkm_pkg::hkm_op_type'(op_ff) == hkm_pkg::OP_WRITE_LENGTH)
      && (32'(entry_ff) < TABLE_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         size_ff  <= '0;
         open_ff  <= 1'b1;
         ready_ff <= 1'b0;
      end else if (cmd.update) begin
         count_ff <= count_in;
         size_ff  <= size_in;
         open_ff  <= open_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && held_wr) begin
         held_ff[SLOT_W'(count_ff)] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            lengths_ff[i] <= '0;
         end
      end else if (len_wr) begin
         lengths_ff[ENTRY_W'(entry_ff)] <= length_ff;
      end
   end

   // table scan counters
   always_comb begin
      k_in = k_ff;
      priority if (cmd.code_start) begin
         k_in = '0;
      end else if (cmd.code_next) begin
         k_in = k_ff + 1'b1;
      end else begin
         k_in = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      priority if (cmd.update) begin
         e_ff <= '0;
      end else if (cmd.entry_step) begin
         e_ff <= e_ff + 1'b1;
      end else begin
         e_ff <= e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.update) begin
         found_ff <= 1'b0;
      end else if (cmd.hit) begin
         found_ff <= 1'b1;
      end
   end

   assign e_idx   = ENTRY_W'(e_ff);
   assign cur_len = lengths_ff[e_idx];
   assign rd_addr = {e_idx, k_in};
   assign wr_addr = {ENTRY_W'(entry_ff), SLOT_W'(slot_ff)};

   always_ff @(posedge clock) begin
      if (code_wr) begin
         mem[wr_addr] <= tcode_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign status.ready      = ready_ff;
   assign status.entry_done = (e_ff == ECNT_W'(TABLE_ENTRIES));
   assign status.candidate  = (cur_len != 4'd0)
      && (CMP_W'(cur_len) == CMP_W'(size_ff))
      && (CMP_W'(cur_len) <= CMP_W'(COMBO_KEYS));
   assign status.code_eq    = (rd_data_ff == held_ff[k_ff]);
   assign status.last_code  = ((CMP_W'(k_ff) + 1'b1) == CMP_W'(cur_len));

   assign rsp_combo_ready = ready_ff;
   assign rsp_combo_size  = 4'(size_ff);
   assign rsp_match_found = found_ff;
   assign rsp_match_index = found_ff ? 4'(e_ff) : 4'd0;

endmodule

### hdl/hotkey_combo_matcher.sv
// hotkey_combo_matcher: top level joining hkm_ctrl and hkm_datapath, depends on hkm_pkg
// when not ready the table walk stops at its first entry check and the strobe follows;
// when ready it steps through the entries, reading the codes of each entry whose length
// matches one at a time through the single table read port, and stops at the first hit
// throughput: one transaction at a time, next start taken the cycle after the strobe
// reset clears flags, counts, entry lengths and min_keys (to 2); no clearing pass
module hotkey_combo_matcher #(
   parameter int COMBO_KEYS    = 8,
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_event_type,
   input  logic [1:0]  req_event_value,
   input  logic [7:0]  req_key_code,
   input  logic [3:0]  req_entry_index,
   input  logic [2:0]  req_slot_index,
   input  logic [7:0]  req_table_code,
   input  logic [3:0]  req_entry_length,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   output logic        rsp_strobe,
   output logic        rsp_combo_ready,
   output logic [3:0]  rsp_combo_size,
   output logic        rsp_match_found,
   output logic [3:0]  rsp_match_index
);

   hkm_pkg::hkm_cmd_type    cmd;
   hkm_pkg::hkm_status_type status;

   hkm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   hkm_datapath #(
      .COMBO_KEYS    (COMBO_KEYS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_operation    (req_operation),
      .req_event_type   (req_event_type),
      .req_event_value  (req_event_value),
      .req_key_code     (req_key_code),
      .req_entry_index  (req_entry_index),
      .req_slot_index   (req_slot_index),
      .req_table_code   (req_table_code),
      .req_entry_length (req_entry_length),
      .rsp_combo_ready  (rsp_combo_ready),
      .rsp_combo_size   (rsp_combo_size),
      .rsp_match_found  (rsp_match_found),
      .rsp_match_index  (rsp_match_index)
   );

endmodule

### tb/tb_top.sv
// tb_top: self-checking bench for hotkey_combo_matcher; a directed stimulus table, then
// random key sequences and shortcut table programming; rows not typed use a local predictor
// depends on hkm_pkg and hotkey_combo_matcher
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COMBO_KEYS      = 8;
   localparam int TABLE_ENTRIES   = 16;
   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 200;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int DIR_ROWS        = 27;

   localparam logic [1:0] EV_REPEAT   = 2'd2;
   localparam logic [1:0] EV_RESERVED = 2'd3;

   typedef struct packed {
      hkm_pkg::hkm_op_type op;
      logic [15:0]         ev_type;
      logic [1:0]          ev_value;
      logic [7:0]          key;
      logic [3:0]          entry;
      logic [2:0]          slot;
      logic [7:0]          code;
      logic [3:0]          len;
   } key_txn_type;

   typedef struct packed {
      logic       ready;
      logic [3:0] size;
      logic       found;
      logic [3:0] index;
   } combo_result_type;

   typedef struct packed {
      key_txn_type      txn;
      logic             typed;
      combo_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_event_type = '0;
   logic [1:0]  req_event_value = '0;
   logic [7:0]  req_key_code = '0;
   logic [3:0]  req_entry_index = '0;
   logic [2:0]  req_slot_index = '0;
   logic [7:0]  req_table_code = '0;
   logic [3:0]  req_entry_length = '0;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = '0;
   logic        rsp_strobe;
   logic        rsp_combo_ready;
   logic [3:0]  rsp_combo_size;
   logic        rsp_match_found;
   logic [3:0]  rsp_match_index;

   // predictor state
   logic [7:0] held_keys [COMBO_KEYS] = '{default: '0};
   logic [3:0] held_num = '0;
   logic [3:0] shown_size = '0;
   logic       combo_armed = 1'b1;
   logic       ready_now = 1'b0;
   logic [7:0] shortcut_codes [TABLE_ENTRIES][COMBO_KEYS];
   logic [3:0] shortcut_len [TABLE_ENTRIES] = '{default: '0};
   logic [3:0] min_keys_now = hkm_pkg::MIN_KEYS_RESET;

   bit               code_written [TABLE_ENTRIES][COMBO_KEYS] = '{default: '{default: 1'b0}};
   combo_result_type pending_results [$];
   bit               steady_sender = 1'b0;
   int               sent_items = 0;
   int               mismatches = 0;
   int               idle_cycles = 0;

   stim_row_type dir_rows [DIR_ROWS] = '{
      '{'{hkm_pkg::OP_NONE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_RELEASE, 8'h00, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, 16'hffff, hkm_pkg::EV_PRESS, 8'hff, 4'd0, 3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_CODE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd15, 3'd0, 8'hff,
          4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_CODE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd15, 3'd1, 8'h00,
          4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_CODE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd0, 8'hff,
          4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_CODE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd1, 8'h01,
          4'd0},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_LENGTH, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd0, 8'h00,
          4'd2},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_WRITE_LENGTH, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd15, 3'd0, 8'h00,
          4'd2},
        1'b1, '{1'b0, 4'd0, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'hff, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd1, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h00, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd2, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, EV_REPEAT, 8'h55, 4'd0, 3'd0, 8'h00,
          4'd0},
        1'b1, '{1'b0, 4'd2, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, EV_RESERVED, 8'haa, 4'd0, 3'd0,
          8'h00, 4'd0},
        1'b1, '{1'b0, 4'd2, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_RELEASE, 8'h00, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b1, 4'd2, 1'b1, 4'd15}},
      // rewrite while ready: lower entry matches first until its length is cleared to zero
      '{'{hkm_pkg::OP_WRITE_CODE, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd1, 8'h00,
          4'd0},
        1'b0, '0},
      '{'{hkm_pkg::OP_WRITE_LENGTH, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd3, 3'd0, 8'h00,
          4'd15},
        1'b0, '0},
      '{'{hkm_pkg::OP_WRITE_LENGTH, 16'h0000, hkm_pkg::EV_RELEASE, 8'h00, 4'd0, 3'd0, 8'h00,
          4'd0},
        1'b0, '0},
      // nine presses, the last one finds the list full
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h01, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd1, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h02, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd2, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h03, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd3, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h04, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd4, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h05, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd5, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h06, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd6, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h07, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd7, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'h08, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd8, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_PRESS, 8'hff, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b0, 4'd8, 1'b0, 4'd0}},
      '{'{hkm_pkg::OP_KEY_EVENT, hkm_pkg::KEY_EVENT_TYPE, hkm_pkg::EV_RELEASE, 8'h00, 4'd0,
          3'd0, 8'h00, 4'd0},
        1'b1, '{1'b1, 4'd8, 1'b0, 4'd0}}
   };

   hotkey_combo_matcher #(
      .COMBO_KEYS   (COMBO_KEYS),
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_event_type  (req_event_type),
      .req_event_value (req_event_value),
      .req_key_code    (req_key_code),
      .req_entry_index (req_entry_index),
      .req_slot_index  (req_slot_index),
      .req_table_code  (req_table_code),
      .req_entry_length(req_entry_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_combo_ready (rsp_combo_ready),
      .rsp_combo_size  (rsp_combo_size),
      .rsp_match_found (rsp_match_found),
      .rsp_match_index (rsp_match_index)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic combo_result_type combo_predict(input key_txn_type t);
      combo_result_type r;
      bit               same;
      r = '0;
      case (t.op)
         hkm_pkg::OP_KEY_EVENT: begin
            if (t.ev_type != hkm_pkg::KEY_EVENT_TYPE) begin
               ready_now = 1'b0;
            end else if (t.ev_value == hkm_pkg::EV_RELEASE) begin
               shown_size  = held_num;
               ready_now   = (held_num >= min_keys_now) && combo_armed;
               combo_armed = 1'b0;
               held_num    = '0;
            end else if (t.ev_value == hkm_pkg::EV_PRESS) begin
               if (held_num < COMBO_KEYS) begin
                  held_keys[held_num] = t.key;
                  held_num = held_num + 4'd1;
               end
               shown_size  = held_num;
               ready_now   = 1'b0;
               combo_armed = 1'b1;
            end
         end
         hkm_pkg::OP_WRITE_CODE:   shortcut_codes[t.entry][t.slot] = t.code;
         hkm_pkg::OP_WRITE_LENGTH: shortcut_len[t.entry] = t.len;
         default: ;
      endcase
      r.ready = ready_now;
      r.size  = shown_size;
      if (ready_now) begin
         for (int e = 0; e < TABLE_ENTRIES && !r.found; e++) begin
            if (shortcut_len[e] != 0 && shortcut_len[e] == shown_size &&
                shortcut_len[e] <= COMBO_KEYS) begin
               same = 1'b1;
               for (int k = 0; k < shortcut_len[e]; k++)
                  if (shortcut_codes[e][k] != held_keys[k]) same = 1'b0;
               if (same) begin
                  r.found = 1'b1;
                  r.index = 4'(e);
               end
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic send_txn(input key_txn_type t, input logic typed,
                           input combo_result_type want);
      combo_result_type predicted;
      while (!steady_sender && $urandom_range(0, 99) < 11) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_operation    <= t.op;
      req_event_type   <= t.ev_type;
      req_event_value  <= t.ev_value;
      req_key_code     <= t.key;
      req_entry_index  <= t.entry;
      req_slot_index   <= t.slot;
      req_table_code   <= t.code;
      req_entry_length <= t.len;
      start            <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = combo_predict(t);
      pending_results.push_back(typed ? want : predicted);
      if (t.op == hkm_pkg::OP_WRITE_CODE) code_written[t.entry][t.slot] = 1'b1;
      if (t.op != hkm_pkg::OP_NONE) sent_items++;
   endtask

   task automatic write_min_keys(input logic [3:0] value);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      min_keys_now = value;
   endtask

   function automatic key_txn_type random_txn();
      key_txn_type t;
      t.op       = hkm_pkg::hkm_op_type'(2'($urandom_range(0, 3)));
      t.ev_type  = 16'($urandom_range(0, 16'hffff));
      t.ev_value = 2'($urandom_range(0, 3));
      t.key      = 8'($urandom_range(0, 255));
      t.entry    = 4'($urandom_range(0, TABLE_ENTRIES - 1));
      t.slot     = 3'($urandom_range(0, COMBO_KEYS - 1));
      t.code     = 8'($urandom_range(0, 255));
      t.len      = 4'($urandom_range(0, 15));
      return t;
   endfunction

   // small alphabet so that combos and entries collide often
   function automatic logic [7:0] pick_code();
      case ($urandom_range(0, 4))
         0: return 8'h1d;
         1: return 8'h38;
         2: return 8'h2a;
         3: return 8'h0f;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic play_combo();
      key_txn_type t;
      int          e;
      int          n;
      int          flip;
      logic [7:0]  key_seq [COMBO_KEYS + 1];
      e = $urandom_range(0, TABLE_ENTRIES - 1);
      if (shortcut_len[e] >= 1 && shortcut_len[e] <= COMBO_KEYS &&
          $urandom_range(0, 9) < 6) begin
         n = shortcut_len[e];
         for (int k = 0; k < n; k++) key_seq[k] = shortcut_codes[e][k];
         if ($urandom_range(0, 9) == 0) begin
            flip = $urandom_range(0, n - 1);
            key_seq[flip] = key_seq[flip] ^ 8'h01;
         end
      end else begin
         n = $urandom_range(1, COMBO_KEYS + 1);
         for (int k = 0; k < n; k++) key_seq[k] = pick_code();
      end
      t = random_txn();
      t.op      = hkm_pkg::OP_KEY_EVENT;
      t.ev_type = hkm_pkg::KEY_EVENT_TYPE;
      for (int k = 0; k < n; k++) begin
         t.ev_value = hkm_pkg::EV_PRESS;
         t.key      = key_seq[k];
         send_txn(t, 1'b0, '0);
         if ($urandom_range(0, 9) == 0) begin
            t.ev_value = EV_REPEAT;
            send_txn(t, 1'b0, '0);
         end
      end
      t.ev_value = hkm_pkg::EV_RELEASE;
      send_txn(t, 1'b0, '0);
      // second release hits a closed combo
      if ($urandom_range(0, 9) == 0) send_txn(t, 1'b0, '0);
   endtask

   task automatic program_entry();
      key_txn_type t;
      int          e;
      int          src;
      int          n;
      bit          copy;
      e    = $urandom_range(0, TABLE_ENTRIES - 1);
      src  = $urandom_range(0, TABLE_ENTRIES - 1);
      copy = shortcut_len[src] >= 1 && shortcut_len[src] <= COMBO_KEYS &&
             $urandom_range(0, 3) == 0;
      if (copy)
         n = shortcut_len[src];
      else if ($urandom_range(0, 1) == 0)
         n = $urandom_range(min_keys_now, COMBO_KEYS);
      else
         n = $urandom_range(1, COMBO_KEYS);
      t = random_txn();
      t.op    = hkm_pkg::OP_WRITE_CODE;
      t.entry = 4'(e);
      for (int k = 0; k < n; k++) begin
         t.slot = 3'(k);
         t.code = copy ? shortcut_codes[src][k] : pick_code();
         send_txn(t, 1'b0, '0);
      end
      if (n < COMBO_KEYS && $urandom_range(0, 3) == 0) begin
         t.slot = 3'($urandom_range(n, COMBO_KEYS - 1));
         t.code = pick_code();
         send_txn(t, 1'b0, '0);
      end
      t.op = hkm_pkg::OP_WRITE_LENGTH;
      case ($urandom_range(0, 19))
         0:       t.len = 4'd0;
         1, 2:    t.len = 4'($urandom_range(COMBO_KEYS + 1, 15));
         default: t.len = 4'(n);
      endcase
      send_txn(t, 1'b0, '0);
   endtask

   task automatic send_noise();
      key_txn_type t;
      bit          readable;
      t = random_txn();
      if (t.op == hkm_pkg::OP_KEY_EVENT && $urandom_range(0, 1) == 0)
         t.ev_type = hkm_pkg::KEY_EVENT_TYPE;
      // never give an entry a length that covers unwritten codes
      if (t.op == hkm_pkg::OP_WRITE_LENGTH && t.len <= COMBO_KEYS) begin
         readable = 1'b1;
         for (int k = 0; k < t.len; k++)
            if (!code_written[t.entry][k]) readable = 1'b0;
         if (!readable) t.len = 4'd0;
      end
      send_txn(t, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      combo_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            want = pending_results.pop_front();
            if (rsp_combo_ready !== want.ready)
               report_mismatch($sformatf("combo_ready got %b want %b",
                                         rsp_combo_ready, want.ready));
            if (rsp_combo_size !== want.size)
               report_mismatch($sformatf("combo_size got %0d want %0d",
                                         rsp_combo_size, want.size));
            if (rsp_match_found !== want.found)
               report_mismatch($sformatf("match_found got %b want %b",
                                         rsp_match_found, want.found));
            if (rsp_match_index !== want.index)
               report_mismatch($sformatf("match_index got %0d want %0d",
                                         rsp_match_index, want.index));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL hotkey_combo_matcher");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int         goal;
      int         roll;
      logic [3:0] setting;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_txn(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            case (p)
               1:       setting = 4'd1;
               2:       setting = 4'd8;
               4:       setting = hkm_pkg::MIN_KEYS_RESET;
               default: setting = 4'($urandom_range(1, 8));
            endcase
            write_min_keys(setting);
         end
         // one phase runs without sender gaps
         steady_sender = (p == 3);
         goal = sent_items + ITEMS_PER_PHASE;
         while (sent_items < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
               play_combo();
            else if (roll < 75)
               program_entry();
            else
               send_noise();
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS hotkey_combo_matcher");
      else
         $display("FAIL hotkey_combo_matcher");
      $finish;
   end

endmodule

### hotkey_combo_matcher.f
hdl/hkm_pkg.sv
hdl/hkm_ctrl.sv
hdl/hkm_datapath.sv
hdl/hotkey_combo_matcher.sv
tb/tb_top.sv
